@@ rtl/octn_pkg.sv @@
// shared types and constants for the octahedral normal encoder
`default_nettype none

package octn_pkg;

    localparam int CW = 16;          // input component width
    localparam int LW = 17;          // l1 norm and numerator width
    localparam int NW = 33;          // scaled numerator and remainder width
    localparam int DW = 18;          // doubled l1 norm width
    localparam int QW = 15;          // quotient width
    localparam int OW = 16;          // output coordinate width

    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic degen;
    } flags_t;

    typedef struct packed {
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] az;
        logic          y_le0;
        flags_t        flags;
    } abs_t;

    typedef struct packed {
        logic [LW-1:0] l1;
        logic [LW-1:0] nu;
        logic [LW-1:0] nv;
        flags_t        flags;
    } num_t;

    typedef struct packed {
        logic [NW-1:0] rem_u;
        logic [NW-1:0] rem_v;
        logic [QW-1:0] q_u;
        logic [QW-1:0] q_v;
        logic [DW-1:0] den;
        flags_t        flags;
    } div_t;

endpackage

`default_nettype wire

@@ rtl/octn_prep.sv @@
// front stages: magnitudes, l1 norm, rounded scaled numerators
`default_nettype none

module octn_prep
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [15:0]   x,
    input  wire logic signed [15:0]   y,
    input  wire logic signed [15:0]   z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output octn_pkg::div_t            out_data
);

    logic              a_v_reg;
    logic              a_v_next;
    octn_pkg::abs_t    a_reg;
    octn_pkg::abs_t    a_next;
    logic              a_adv;

    logic              b_v_reg;
    logic              b_v_next;
    octn_pkg::num_t    b_reg;
    octn_pkg::num_t    b_next;
    logic              b_adv;

    logic              c_v_reg;
    logic              c_v_next;
    octn_pkg::div_t    c_reg;
    octn_pkg::div_t    c_next;
    logic              c_adv;

    assign c_adv    = !c_v_reg || out_ready;
    assign b_adv    = !b_v_reg || c_adv;
    assign a_adv    = !a_v_reg || b_adv;
    assign in_ready = a_adv;

    always_comb
    begin
        a_next.ax          = x[15] ? 16'(-x) : 16'(x);
        a_next.ay          = y[15] ? 16'(-y) : 16'(y);
        a_next.az          = z[15] ? 16'(-z) : 16'(z);
        a_next.y_le0       = y[15] || (y == 16'sd0);
        a_next.flags.neg_u = x[15];
        a_next.flags.neg_v = z[15];
        a_next.flags.degen = (x == 16'sd0) && (y == 16'sd0) && (z == 16'sd0);
        a_v_next           = a_adv ? in_valid : a_v_reg;
    end

    always_comb
    begin
        b_next.l1    = {1'b0, a_reg.ax} + {1'b0, a_reg.ay} + {1'b0, a_reg.az};
        b_next.nu    = a_reg.y_le0 ? ({1'b0, a_reg.ax} + {1'b0, a_reg.ay})
                                   : {1'b0, a_reg.ax};
        b_next.nv    = a_reg.y_le0 ? ({1'b0, a_reg.az} + {1'b0, a_reg.ay})
                                   : {1'b0, a_reg.az};
        b_next.flags = a_reg.flags;
        b_v_next     = b_adv ? a_v_reg : b_v_reg;
    end

    // numerator 2*32767*n + l1, denominator 2*l1
    always_comb
    begin
        c_next.rem_u = {b_reg.nu, 16'b0} - {15'b0, b_reg.nu, 1'b0} + {16'b0, b_reg.l1};
        c_next.rem_v = {b_reg.nv, 16'b0} - {15'b0, b_reg.nv, 1'b0} + {16'b0, b_reg.l1};
        c_next.q_u   = '0;
        c_next.q_v   = '0;
        c_next.den   = {b_reg.l1, 1'b0};
        c_next.flags = b_reg.flags;
        c_v_next     = c_adv ? b_v_reg : c_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            c_v_reg <= c_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            a_reg <= a_next;
        end
        if (b_adv && a_v_reg)
        begin
            b_reg <= b_next;
        end
        if (c_adv && b_v_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_v_reg;
    assign out_data  = c_reg;

endmodule

`default_nettype wire

@@ rtl/octn_div_stage.sv @@
// one restoring division step for both coordinates
`default_nettype none

module octn_div_stage
#(
    parameter int BIT = 0
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire octn_pkg::div_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output octn_pkg::div_t       out_data
);

    logic                        v_reg;
    logic                        v_next;
    octn_pkg::div_t              d_reg;
    octn_pkg::div_t              d_next;
    logic                        adv;
    logic [octn_pkg::NW-1:0]     shifted;
    logic                        take_u;
    logic                        take_v;

    assign adv      = !v_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        shifted  = {{(octn_pkg::NW - octn_pkg::DW){1'b0}}, in_data.den} << BIT;
        take_u   = in_data.rem_u >= shifted;
        take_v   = in_data.rem_v >= shifted;
        d_next   = in_data;
        if (take_u)
        begin
            d_next.rem_u = in_data.rem_u - shifted;
        end
        if (take_v)
        begin
            d_next.rem_v = in_data.rem_v - shifted;
        end
        d_next.q_u[BIT] = take_u;
        d_next.q_v[BIT] = take_v;
        v_next   = adv ? in_valid : v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

`default_nettype wire

@@ rtl/octahedral_normal_encoder.sv @@
// octahedral normal encoder: q1.15 normal in, two snorm16 coordinates out
// path from input to output: prep stages, divider stages, output register
// throughput one normal per cycle unless stalled; 15-step pipelined divider
// each stage holds its item under back-pressure and fills bubbles as they pass
// reset clears all valid bits; data registers are not reset
`default_nettype none

module octahedral_normal_encoder
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,   // normal_x, normal_y, normal_z
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // oct_u, oct_v
    output logic [0:0]         m_tuser    // degenerate
);

    logic             st_valid [0:octn_pkg::QW];
    logic             st_ready [0:octn_pkg::QW];
    octn_pkg::div_t   st_data  [0:octn_pkg::QW];

    logic                     o_v_reg;
    logic                     o_v_next;
    logic [octn_pkg::OW-1:0]  u_reg;
    logic [octn_pkg::OW-1:0]  u_next;
    logic [octn_pkg::OW-1:0]  v_reg;
    logic [octn_pkg::OW-1:0]  v_next;
    logic                     degen_reg;
    logic [octn_pkg::OW-1:0]  mag_u;
    logic [octn_pkg::OW-1:0]  mag_v;
    logic                     o_adv;

    octn_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x         (s_tdata[15:0]),
        .y         (s_tdata[31:16]),
        .z         (s_tdata[47:32]),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_data  (st_data[0])
    );

    for (genvar i = 0; i < octn_pkg::QW; i++)
    begin : g_div
        octn_div_stage
        #(
            .BIT (octn_pkg::QW - 1 - i)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_data   (st_data[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_data  (st_data[i+1])
        );
    end

    assign o_adv                 = !o_v_reg || m_tready;
    assign st_ready[octn_pkg::QW] = o_adv;

    // all-zero normal gives zero coordinates
    always_comb
    begin
        mag_u    = st_data[octn_pkg::QW].flags.degen ? '0
                 : {1'b0, st_data[octn_pkg::QW].q_u};
        mag_v    = st_data[octn_pkg::QW].flags.degen ? '0
                 : {1'b0, st_data[octn_pkg::QW].q_v};
        u_next   = st_data[octn_pkg::QW].flags.neg_u ? (~mag_u + 16'd1) : mag_u;
        v_next   = st_data[octn_pkg::QW].flags.neg_v ? (~mag_v + 16'd1) : mag_v;
        o_v_next = o_adv ? st_valid[octn_pkg::QW] : o_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_adv && st_valid[octn_pkg::QW])
        begin
            u_reg     <= u_next;
            v_reg     <= v_next;
            degen_reg <= st_data[octn_pkg::QW].flags.degen;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = {v_reg, u_reg};
    assign m_tuser  = degen_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("degenerate result with nonzero coordinates");

    a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000))
        else $error("oct_u outside snorm16 range");

    a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:16] != 16'h8000))
        else $error("oct_v outside snorm16 range");

endmodule

`default_nettype wire
